/* rtl/sorted_id_table_engine_defines.svh */
// Assertion macros for the sorted id table engine.
`ifndef SORTED_ID_TABLE_ENGINE_DEFINES_SVH
`define SORTED_ID_TABLE_ENGINE_DEFINES_SVH
`ifndef ASSERT_OFF
`define STE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define STE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define STE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define STE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* rtl/ste_pkg.sv */
// Shared types and constants of the sorted id table engine.
`default_nettype none
package ste_pkg;
    localparam int ENTRIES_DEF = 64;
    localparam logic [31:0] MARKER = 32'hFFFF_FFFF;

    localparam logic [2:0] KIND_ALLOC   = 3'd0;
    localparam logic [2:0] KIND_INSERT  = 3'd1;
    localparam logic [2:0] KIND_FREE    = 3'd2;
    localparam logic [2:0] KIND_LOOKUP  = 3'd3;
    localparam logic [2:0] KIND_COMPACT = 3'd4;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_DUP       = 2'd2,
        STS_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD,
        OP_CSETUP, OP_CRD, OP_CWR, OP_CEND,
        OP_SSETUP, OP_SRD, OP_SCMP, OP_FRD,
        OP_SHSETUP, OP_SHRD, OP_SHWR,
        OP_INSWR, OP_REVIVE, OP_FREE, OP_ALLOC,
        OP_RESULT
    } op_t;

    typedef struct packed {
        status_t st;
        logic    zero_slot;
        logic    zero_id;
    } res_t;

    typedef struct packed {
        op_t  op;
        res_t res;
    } cmd_t;

    typedef struct packed {
        logic [2:0] kind;
        logic       key_marker;
        logic       full;
        logic       srch_more;
        logic       cmp_more;
        logic       shift_more;
        logic       hit;
        logic       live;
        logic       out_free;
    } stat_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_DISP,
        ST_C_SET, ST_C_CHK, ST_C_RD, ST_C_WR, ST_C_END, ST_POSTC,
        ST_S_SET, ST_S_CHK, ST_S_RD, ST_S_CMP, ST_F_RD, ST_F_HIT,
        ST_SH_SET, ST_SH_CHK, ST_SH_RD, ST_SH_WR,
        ST_INS, ST_REVIVE, ST_FREE, ST_ALLOC, ST_RES
    } state_t;
endpackage
`default_nettype wire

/* rtl/ste_ram.sv */
// Generic single-port RAM with registered read.
`default_nettype none
module ste_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = ste_pkg::ENTRIES_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end
endmodule
`default_nettype wire

/* rtl/ste_dp.sv */
// Datapath: table RAM, marks, search and scan registers, result register.
`default_nettype none
module ste_dp #(
    parameter int ENTRIES = ste_pkg::ENTRIES_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [2:0]     kind,
    input  wire logic [31:0]    key_id,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [1:0]          status,
    output logic [5:0]          slot,
    output logic [31:0]         entry_id,
    output logic [6:0]          used_count,
    input  wire ste_pkg::cmd_t  cmd,
    output ste_pkg::stat_t      sts
);
    localparam int AW = $clog2(ENTRIES);
    localparam int FW = $clog2(ENTRIES + 1);

    logic [2:0]    kind_reg, kind_next;
    logic [31:0]   key_reg, key_next;
    logic [FW-1:0] fill_reg, fill_next;
    logic [FW-1:0] low_reg, low_next;
    logic [FW-1:0] lo_reg, lo_next;
    logic [FW-1:0] hi_reg, hi_next;
    logic [FW-1:0] idx_reg, idx_next;
    logic [FW-1:0] dst_reg, dst_next;
    logic [31:0]   fresh_reg, fresh_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg, status_next;
    logic [5:0]    slot_reg, slot_next;
    logic [31:0]   entry_reg, entry_next;
    logic [6:0]    used_reg, used_next;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_addr;
    logic [32:0]   ram_wdata, ram_rdata;
    logic          rd_live;
    logic [31:0]   rd_id;
    logic [FW:0]   mid_sum;
    logic [FW-1:0] mid;
    logic [FW-1:0] idx_m1;
    logic [FW-1:0] low_clamp;
    logic [31:0]   fresh_use;

    ste_ram #(.WIDTH(33), .DEPTH(ENTRIES)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign rd_live   = ram_rdata[32];
    assign rd_id     = ram_rdata[31:0];
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[FW:1];
    assign idx_m1    = idx_reg - FW'(1);
    assign low_clamp = (low_reg > fill_reg) ? fill_reg : low_reg;
    // the counter skips the empty marker
    assign fresh_use = (fresh_reg == ste_pkg::MARKER) ? 32'd0 : fresh_reg;

    always_comb
    begin
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_addr  = lo_reg[AW-1:0];
        ram_wdata = ram_rdata;
        unique case (cmd.op) inside
            ste_pkg::OP_CRD:
            begin
                ram_re   = 1'b1;
                ram_addr = idx_reg[AW-1:0];
            end
            ste_pkg::OP_CWR:
            begin
                ram_we   = rd_live;
                ram_addr = dst_reg[AW-1:0];
            end
            ste_pkg::OP_SRD:
            begin
                ram_re   = 1'b1;
                ram_addr = mid[AW-1:0];
            end
            ste_pkg::OP_FRD:
            begin
                ram_re = 1'b1;
            end
            ste_pkg::OP_SHRD:
            begin
                ram_re   = 1'b1;
                ram_addr = idx_m1[AW-1:0];
            end
            ste_pkg::OP_SHWR:
            begin
                ram_we   = 1'b1;
                ram_addr = idx_reg[AW-1:0];
            end
            ste_pkg::OP_INSWR, ste_pkg::OP_REVIVE:
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b1, key_reg};
            end
            ste_pkg::OP_FREE:
            begin
                ram_we    = 1'b1;
                ram_wdata = {1'b0, key_reg};
            end
            ste_pkg::OP_ALLOC:
            begin
                ram_we    = 1'b1;
                ram_addr  = fill_reg[AW-1:0];
                ram_wdata = {1'b1, fresh_use};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        kind_next      = kind_reg;
        key_next       = key_reg;
        fill_next      = fill_reg;
        low_next       = low_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        idx_next       = idx_reg;
        dst_next       = dst_reg;
        fresh_next     = fresh_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        entry_next     = entry_reg;
        used_next      = used_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (cmd.op)
            ste_pkg::OP_LOAD:
            begin
                kind_next = kind;
                key_next  = key_id;
            end
            ste_pkg::OP_CSETUP:
            begin
                low_next = low_clamp;
                idx_next = low_clamp;
                dst_next = low_clamp;
            end
            ste_pkg::OP_CWR:
            begin
                idx_next = idx_reg + FW'(1);
                if (rd_live)
                begin
                    dst_next = dst_reg + FW'(1);
                end
            end
            ste_pkg::OP_CEND:
            begin
                fill_next = dst_reg;
                low_next  = dst_reg;
            end
            ste_pkg::OP_SSETUP:
            begin
                lo_next = '0;
                hi_next = fill_reg;
            end
            ste_pkg::OP_SCMP:
            begin
                if (rd_id < key_reg)
                begin
                    lo_next = mid + FW'(1);
                end
                else
                begin
                    hi_next = mid;
                end
            end
            ste_pkg::OP_SHSETUP:
            begin
                idx_next = fill_reg;
            end
            ste_pkg::OP_SHWR:
            begin
                idx_next = idx_m1;
            end
            ste_pkg::OP_INSWR:
            begin
                fill_next = fill_reg + FW'(1);
            end
            ste_pkg::OP_FREE:
            begin
                if (lo_reg < low_reg)
                begin
                    low_next = lo_reg;
                end
                // freeing the topmost entry pulls the fill mark down
                if (lo_reg + FW'(1) == fill_reg)
                begin
                    fill_next = fill_reg - FW'(1);
                end
            end
            ste_pkg::OP_ALLOC:
            begin
                lo_next    = fill_reg;
                fill_next  = fill_reg + FW'(1);
                key_next   = fresh_use;
                fresh_next = fresh_use + 32'd1;
            end
            ste_pkg::OP_RESULT:
            begin
                status_next    = cmd.res.st;
                slot_next      = cmd.res.zero_slot ? 6'd0 : 6'(lo_reg);
                entry_next     = cmd.res.zero_id ? 32'd0 : key_reg;
                used_next      = 7'(fill_reg);
                out_valid_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            low_reg       <= '0;
            fresh_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            low_reg       <= low_next;
            fresh_reg     <= fresh_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        idx_reg    <= idx_next;
        dst_reg    <= dst_next;
        status_reg <= status_next;
        slot_reg   <= slot_next;
        entry_reg  <= entry_next;
        used_reg   <= used_next;
    end

    assign sts.kind       = kind_reg;
    assign sts.key_marker = (key_reg == ste_pkg::MARKER);
    assign sts.full       = (fill_reg == FW'(ENTRIES));
    assign sts.srch_more  = (lo_reg < hi_reg);
    assign sts.cmp_more   = (idx_reg < fill_reg);
    assign sts.shift_more = (idx_reg > lo_reg);
    assign sts.hit        = (lo_reg < fill_reg) && (rd_id == key_reg);
    assign sts.live       = rd_live;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign slot       = slot_reg;
    assign entry_id   = entry_reg;
    assign used_count = used_reg;
endmodule
`default_nettype wire

/* rtl/ste_ctrl.sv */
// Controller: sequences compaction, search, shift, write and result steps.
`default_nettype none
module ste_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire ste_pkg::stat_t sts,
    output ste_pkg::cmd_t       cmd
);
    ste_pkg::state_t state_reg, state_next;
    ste_pkg::res_t   res_reg, res_next;

    function automatic ste_pkg::res_t mk_res(input ste_pkg::status_t st,
                                             input logic zs, input logic zi);
        ste_pkg::res_t r;
        r.st        = st;
        r.zero_slot = zs;
        r.zero_id   = zi;
        return r;
    endfunction

    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        unique case (state_reg) inside
            ste_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ste_pkg::ST_DISP;
                end
            end
            ste_pkg::ST_DISP:
            begin
                case (sts.kind) inside
                    ste_pkg::KIND_ALLOC:
                    begin
                        state_next = sts.full ? ste_pkg::ST_C_SET : ste_pkg::ST_ALLOC;
                    end
                    ste_pkg::KIND_INSERT:
                    begin
                        if (sts.key_marker)
                        begin
                            res_next   = mk_res(ste_pkg::STS_NOT_FOUND, 1'b1, 1'b0);
                            state_next = ste_pkg::ST_RES;
                        end
                        else
                        begin
                            state_next = sts.full ? ste_pkg::ST_C_SET : ste_pkg::ST_S_SET;
                        end
                    end
                    ste_pkg::KIND_FREE, ste_pkg::KIND_LOOKUP:
                    begin
                        if (sts.key_marker)
                        begin
                            res_next   = mk_res(ste_pkg::STS_NOT_FOUND, 1'b1, 1'b0);
                            state_next = ste_pkg::ST_RES;
                        end
                        else
                        begin
                            state_next = ste_pkg::ST_S_SET;
                        end
                    end
                    ste_pkg::KIND_COMPACT:
                    begin
                        state_next = ste_pkg::ST_C_SET;
                    end
                    default:
                    begin
                        res_next   = mk_res(ste_pkg::STS_NOT_FOUND, 1'b1, 1'b1);
                        state_next = ste_pkg::ST_RES;
                    end
                endcase
            end
            ste_pkg::ST_C_SET: state_next = ste_pkg::ST_C_CHK;
            ste_pkg::ST_C_CHK:
            begin
                state_next = sts.cmp_more ? ste_pkg::ST_C_RD : ste_pkg::ST_C_END;
            end
            ste_pkg::ST_C_RD:  state_next = ste_pkg::ST_C_WR;
            ste_pkg::ST_C_WR:  state_next = ste_pkg::ST_C_CHK;
            ste_pkg::ST_C_END: state_next = ste_pkg::ST_POSTC;
            ste_pkg::ST_POSTC:
            begin
                if (sts.kind == ste_pkg::KIND_ALLOC)
                begin
                    if (sts.full)
                    begin
                        res_next   = mk_res(ste_pkg::STS_FULL, 1'b1, 1'b1);
                        state_next = ste_pkg::ST_RES;
                    end
                    else
                    begin
                        state_next = ste_pkg::ST_ALLOC;
                    end
                end
                else if (sts.kind == ste_pkg::KIND_INSERT)
                begin
                    if (sts.full)
                    begin
                        res_next   = mk_res(ste_pkg::STS_FULL, 1'b1, 1'b0);
                        state_next = ste_pkg::ST_RES;
                    end
                    else
                    begin
                        state_next = ste_pkg::ST_S_SET;
                    end
                end
                else
                begin
                    res_next   = mk_res(ste_pkg::STS_OK, 1'b1, 1'b1);
                    state_next = ste_pkg::ST_RES;
                end
            end
            ste_pkg::ST_S_SET: state_next = ste_pkg::ST_S_CHK;
            ste_pkg::ST_S_CHK:
            begin
                state_next = sts.srch_more ? ste_pkg::ST_S_RD : ste_pkg::ST_F_RD;
            end
            ste_pkg::ST_S_RD:  state_next = ste_pkg::ST_S_CMP;
            ste_pkg::ST_S_CMP: state_next = ste_pkg::ST_S_CHK;
            ste_pkg::ST_F_RD:  state_next = ste_pkg::ST_F_HIT;
            ste_pkg::ST_F_HIT:
            begin
                if (sts.kind == ste_pkg::KIND_INSERT)
                begin
                    if (sts.hit && sts.live)
                    begin
                        res_next   = mk_res(ste_pkg::STS_DUP, 1'b0, 1'b0);
                        state_next = ste_pkg::ST_RES;
                    end
                    else if (sts.hit)
                    begin
                        state_next = ste_pkg::ST_REVIVE;
                    end
                    else
                    begin
                        state_next = ste_pkg::ST_SH_SET;
                    end
                end
                else if (sts.hit && sts.live)
                begin
                    if (sts.kind == ste_pkg::KIND_FREE)
                    begin
                        state_next = ste_pkg::ST_FREE;
                    end
                    else
                    begin
                        res_next   = mk_res(ste_pkg::STS_OK, 1'b0, 1'b0);
                        state_next = ste_pkg::ST_RES;
                    end
                end
                else
                begin
                    res_next   = mk_res(ste_pkg::STS_NOT_FOUND, 1'b1, 1'b0);
                    state_next = ste_pkg::ST_RES;
                end
            end
            ste_pkg::ST_SH_SET: state_next = ste_pkg::ST_SH_CHK;
            ste_pkg::ST_SH_CHK:
            begin
                state_next = sts.shift_more ? ste_pkg::ST_SH_RD : ste_pkg::ST_INS;
            end
            ste_pkg::ST_SH_RD: state_next = ste_pkg::ST_SH_WR;
            ste_pkg::ST_SH_WR: state_next = ste_pkg::ST_SH_CHK;
            ste_pkg::ST_INS, ste_pkg::ST_REVIVE, ste_pkg::ST_FREE, ste_pkg::ST_ALLOC:
            begin
                res_next   = mk_res(ste_pkg::STS_OK, 1'b0, 1'b0);
                state_next = ste_pkg::ST_RES;
            end
            ste_pkg::ST_RES:
            begin
                if (sts.out_free)
                begin
                    state_next = ste_pkg::ST_IDLE;
                end
            end
            default: state_next = ste_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op  = ste_pkg::OP_NONE;
        cmd.res = res_reg;
        unique case (state_reg)
            ste_pkg::ST_IDLE:   cmd.op = in_valid ? ste_pkg::OP_LOAD : ste_pkg::OP_NONE;
            ste_pkg::ST_C_SET:  cmd.op = ste_pkg::OP_CSETUP;
            ste_pkg::ST_C_RD:   cmd.op = ste_pkg::OP_CRD;
            ste_pkg::ST_C_WR:   cmd.op = ste_pkg::OP_CWR;
            ste_pkg::ST_C_END:  cmd.op = ste_pkg::OP_CEND;
            ste_pkg::ST_S_SET:  cmd.op = ste_pkg::OP_SSETUP;
            ste_pkg::ST_S_RD:   cmd.op = ste_pkg::OP_SRD;
            ste_pkg::ST_S_CMP:  cmd.op = ste_pkg::OP_SCMP;
            ste_pkg::ST_F_RD:   cmd.op = ste_pkg::OP_FRD;
            ste_pkg::ST_SH_SET: cmd.op = ste_pkg::OP_SHSETUP;
            ste_pkg::ST_SH_RD:  cmd.op = ste_pkg::OP_SHRD;
            ste_pkg::ST_SH_WR:  cmd.op = ste_pkg::OP_SHWR;
            ste_pkg::ST_INS:    cmd.op = ste_pkg::OP_INSWR;
            ste_pkg::ST_REVIVE: cmd.op = ste_pkg::OP_REVIVE;
            ste_pkg::ST_FREE:   cmd.op = ste_pkg::OP_FREE;
            ste_pkg::ST_ALLOC:  cmd.op = ste_pkg::OP_ALLOC;
            ste_pkg::ST_RES:
            begin
                cmd.op = sts.out_free ? ste_pkg::OP_RESULT : ste_pkg::OP_NONE;
            end
            default:            cmd.op = ste_pkg::OP_NONE;
        endcase
    end

    assign in_stall = (state_reg != ste_pkg::ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ste_pkg::ST_IDLE;
            res_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end
endmodule
`default_nettype wire

/* rtl/sorted_id_table_engine.sv */
// Sorted id table engine top level: one request in, one result out.
// Lookup and free run a binary search, free then marks its entry dead; insert shifts the
// entries above its slot up, and compact scans the slots from the low mark to the fill mark.
// Throughput: one request at a time, bound by the single-port table RAM loops.
// Reset (rst_n, async low): table empty, fill mark, low mark and fresh id at zero;
// no clearing pass, slots at or above the fill mark may be read but their contents are never used.
`default_nettype none
`include "sorted_id_table_engine_defines.svh"
module sorted_id_table_engine #(
    parameter int ENTRIES = ste_pkg::ENTRIES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [31:0] key_id,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       status,
    output logic [5:0]       slot,
    output logic [31:0]      entry_id,
    output logic [6:0]       used_count
);
    // controller issues one datapath command per cycle and reads back status
    ste_pkg::cmd_t  cmd;
    ste_pkg::stat_t sts;

    ste_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // the result register lets a new request start while the last result waits
    ste_dp #(.ENTRIES(ENTRIES)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .kind       (kind),
        .key_id     (key_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .slot       (slot),
        .entry_id   (entry_id),
        .used_count (used_count),
        .cmd        (cmd),
        .sts        (sts)
    );

    `STE_ASSERT_NXT(a_busy_after_req, clk, rst_n, in_valid && !in_stall, in_stall, "request not held off")
    `STE_ASSERT_IMP(a_nf_slot0, clk, rst_n, out_valid && status == ste_pkg::STS_NOT_FOUND, slot == 6'd0, "not found with slot")
    `STE_ASSERT_IMP(a_full_slot0, clk, rst_n, out_valid && status == ste_pkg::STS_FULL, slot == 6'd0, "full with slot")
    `STE_ASSERT_IMP(a_used_range, clk, rst_n, out_valid, 32'(used_count) <= 32'(ENTRIES), "fill mark out of range")
endmodule
`default_nettype wire

/* verif/tb.sv */
// Regression bench for the sorted id table engine: directed and random requests, scoreboarded.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import ste_pkg::*;

    localparam int SLOTS     = ENTRIES_DEF;
    localparam int IDLE_PCT  = 19;
    localparam int WD_LIMIT  = 20000;   // far above the worst request latency plus stalls
    localparam int DRAIN_CYC = 4 * SLOTS + 40;
    localparam logic [2:0] KIND_BAD   = 3'd7;
    localparam logic [2:0] KIND_RSV_A = 3'd5;
    localparam logic [2:0] KIND_RSV_B = 3'd6;

    typedef struct packed {
        status_t     st;
        logic [5:0]  slot;
        logic [31:0] id;
        logic [6:0]  used;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  kind;
    logic [31:0] key_id;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [31:0] entry_id;
    logic [6:0]  used_count;

    sorted_id_table_engine i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .key_id     (key_id),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .slot       (slot),
        .entry_id   (entry_id),
        .used_count (used_count)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Shadow copy of the table, updated as each request is accepted.
    logic [31:0] tbl_id[SLOTS];
    logic        tbl_live[SLOTS];
    int unsigned tbl_fill;
    int unsigned tbl_low;
    logic [31:0] fresh_ctr;

    outcome_t    pending_q[$];
    int          err_cnt;
    int          idle_wd;
    bit          calm;          // no idling on either side while set
    bit          timed_out;
    logic [31:0] issued_ids[$]; // ids sent with an insert request, other than the marker

    task automatic report(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        err_cnt++;
    endtask

    function automatic void tbl_clear();
        for (int i = 0; i < SLOTS; i++)
        begin
            tbl_id[i]   = MARKER;
            tbl_live[i] = 1'b0;
        end
        tbl_fill  = 0;
        tbl_low   = 0;
        fresh_ctr = '0;
    endfunction

    // Remove dead entries between the low mark and the fill mark.
    function automatic void tbl_squeeze();
        int unsigned dst;
        if (tbl_low > tbl_fill)
            tbl_low = tbl_fill;
        dst = tbl_low;
        for (int unsigned i = tbl_low; i < tbl_fill; i++)
        begin
            if (tbl_live[i])
            begin
                tbl_id[dst]   = tbl_id[i];
                tbl_live[dst] = 1'b1;
                dst++;
            end
        end
        for (int unsigned i = dst; i < tbl_fill; i++)
        begin
            tbl_id[i]   = MARKER;
            tbl_live[i] = 1'b0;
        end
        tbl_fill = dst;
        tbl_low  = dst;
    endfunction

    // Lower-bound search; dead entries take part.
    function automatic int unsigned tbl_search(input logic [31:0] key, output bit hit);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = tbl_fill;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            if (tbl_id[mid] < key)
                lo = mid + 1;
            else
                hi = mid;
        end
        hit = (lo < tbl_fill) && (tbl_id[lo] == key);
        return lo;
    endfunction

    function automatic outcome_t mk(input status_t st, input int unsigned sl,
                                    input logic [31:0] id);
        outcome_t o;
        o.st   = st;
        o.slot = sl[5:0];
        o.id   = id;
        o.used = tbl_fill[6:0];
        return o;
    endfunction

    function automatic outcome_t table_apply(input logic [2:0] k, input logic [31:0] key);
        int unsigned pos;
        bit          hit;
        case (k)
            KIND_ALLOC:
            begin
                if (tbl_fill >= SLOTS)
                    tbl_squeeze();
                if (tbl_fill >= SLOTS)
                    return mk(STS_FULL, 0, '0);
                if (fresh_ctr == MARKER)
                    fresh_ctr = '0;
                pos = tbl_fill;
                tbl_id[pos]   = fresh_ctr;
                tbl_live[pos] = 1'b1;
                tbl_fill++;
                fresh_ctr++;
                return mk(STS_OK, pos, tbl_id[pos]);
            end
            KIND_INSERT:
            begin
                if (key == MARKER)
                    return mk(STS_NOT_FOUND, 0, key);
                if (tbl_fill >= SLOTS)
                    tbl_squeeze();
                if (tbl_fill >= SLOTS)
                    return mk(STS_FULL, 0, key);
                pos = tbl_search(key, hit);
                if (hit)
                begin
                    if (tbl_live[pos])
                        return mk(STS_DUP, pos, key);
                    tbl_live[pos] = 1'b1;
                    return mk(STS_OK, pos, key);
                end
                for (int unsigned i = tbl_fill; i > pos; i--)
                begin
                    tbl_id[i]   = tbl_id[i-1];
                    tbl_live[i] = tbl_live[i-1];
                end
                tbl_id[pos]   = key;
                tbl_live[pos] = 1'b1;
                tbl_fill++;
                return mk(STS_OK, pos, key);
            end
            KIND_FREE:
            begin
                if (key == MARKER)
                    return mk(STS_NOT_FOUND, 0, key);
                pos = tbl_search(key, hit);
                if (!hit || !tbl_live[pos])
                    return mk(STS_NOT_FOUND, 0, key);
                if (pos < tbl_low)
                    tbl_low = pos;
                tbl_live[pos] = 1'b0;
                if (pos + 1 == tbl_fill)
                begin
                    tbl_fill--;
                    tbl_id[pos] = MARKER;
                end
                return mk(STS_OK, pos, key);
            end
            KIND_LOOKUP:
            begin
                if (key == MARKER)
                    return mk(STS_NOT_FOUND, 0, key);
                pos = tbl_search(key, hit);
                if (!hit || !tbl_live[pos])
                    return mk(STS_NOT_FOUND, 0, key);
                return mk(STS_OK, pos, key);
            end
            KIND_COMPACT:
            begin
                tbl_squeeze();
                return mk(STS_OK, 0, '0);
            end
            default:
                return mk(STS_NOT_FOUND, 0, '0);
        endcase
    endfunction

    // Send one request; prediction happens at the accepting edge.
    task automatic send_req(input logic [2:0] k, input logic [31:0] key);
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        key_id   <= key;
        do
            @(posedge clk);
        while (in_stall);
        pending_q.push_back(table_apply(k, key));
        if (k == KIND_INSERT && key != MARKER)
            issued_ids.push_back(key);
        in_valid <= 1'b0;
        @(posedge clk);                 // the block stalls new requests while it works anyway
    endtask

    task automatic wait_drained();
        while (pending_q.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random stall, check each accepted result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b1;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_q.size() == 0)
                    report("result with no request outstanding");
                else
                begin
                    outcome_t e;
                    e = pending_q.pop_front();
                    if (status !== e.st)
                        report($sformatf("status %0d, want %0d", status, e.st));
                    if (slot !== e.slot)
                        report($sformatf("slot %0d, want %0d", slot, e.slot));
                    if (entry_id !== e.id)
                        report($sformatf("entry_id %h, want %h", entry_id, e.id));
                    if (used_count !== e.used)
                        report($sformatf("used_count %0d, want %0d", used_count, e.used));
                end
            end
            out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Watchdog on cycles with no handshake at all.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_wd <= 0;
        else
            idle_wd <= idle_wd + 1;
    end

    always @(posedge clk)
    begin
        if (idle_wd >= WD_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog: no progress for %0d cycles", WD_LIMIT);
            $display("sorted_id_table_engine regression: fail");
            $finish;
        end
    end

    function automatic logic [31:0] rand_key();
        case ($urandom_range(3))
            0: return $urandom_range(15);
            1: return 32'hFFFF_FFF0 + $urandom_range(15);   // marker and its neighbours
            default: return $urandom();
        endcase
    endfunction

    // Key biased toward ids named in earlier inserts or held in the table.
    function automatic logic [31:0] known_key();
        if (issued_ids.size() != 0 && $urandom_range(99) < 70)
            return issued_ids[$urandom_range(issued_ids.size() - 1)];
        if (tbl_fill != 0 && $urandom_range(1))
            return tbl_id[$urandom_range(tbl_fill - 1)];
        return rand_key();
    endfunction

    // Every operation, both extremes of the key, marker keys and the unknown kinds.
    task automatic test_directed();
        send_req(KIND_LOOKUP, 32'd5);           // empty table
        send_req(KIND_FREE, 32'd5);             // free of an absent id
        send_req(KIND_ALLOC, 32'hDEAD_BEEF);    // key ignored
        send_req(KIND_INSERT, 32'hFFFF_FFFE);   // largest usable id
        send_req(KIND_INSERT, 32'd0);           // duplicate of the alloc'd id
        send_req(KIND_INSERT, 32'd7);
        send_req(KIND_INSERT, MARKER);
        send_req(KIND_FREE, MARKER);
        send_req(KIND_LOOKUP, MARKER);
        send_req(KIND_LOOKUP, 32'd7);
        send_req(KIND_FREE, 32'd7);             // middle entry goes dead
        send_req(KIND_FREE, 32'd7);             // already dead
        send_req(KIND_LOOKUP, 32'd7);
        send_req(KIND_INSERT, 32'd7);           // revive
        send_req(KIND_FREE, 32'hFFFF_FFFE);     // topmost: fill mark shrinks
        send_req(KIND_FREE, 32'd0);
        send_req(KIND_COMPACT, 32'hFFFF_FFFF);
        send_req(KIND_BAD, 32'd7);
        send_req(KIND_RSV_A, 32'd0);
        send_req(KIND_RSV_B, 32'hAAAA_5555);
        send_req(KIND_ALLOC, 32'h5555_AAAA);
    endtask

    // Fill to the top, free some, then alloc and insert must compact on their own.
    task automatic test_full();
        while (tbl_fill < SLOTS)
            send_req(KIND_ALLOC, $urandom());
        send_req(KIND_ALLOC, '0);               // full, nothing dead
        send_req(KIND_INSERT, 32'h8000_0000);   // full, nothing dead
        for (int i = 0; i < 6; i++)
            send_req(KIND_FREE, tbl_id[$urandom_range(SLOTS - 2)]);
        send_req(KIND_ALLOC, '0);
        send_req(KIND_INSERT, 32'h4000_0000);
        wait_drained();                         // sender holds off until all results are in
        repeat (DRAIN_CYC) @(posedge clk);
        send_req(KIND_COMPACT, '0);
    endtask

    // Random mix, mostly against known ids; one stretch of 120 requests with no idling.
    task automatic test_random(input int n);
        logic [2:0]  k;
        int unsigned r;
        for (int i = 0; i < n; i++)
        begin
            calm = (i >= n / 3) && (i < n / 3 + 120);
            r = $urandom_range(99);
            if (r < 18)       k = KIND_ALLOC;
            else if (r < 45)  k = KIND_INSERT;
            else if (r < 68)  k = KIND_FREE;
            else if (r < 90)  k = KIND_LOOKUP;
            else if (r < 96)  k = KIND_COMPACT;
            else              k = 3'($urandom_range(5, 7));
            if (k == KIND_INSERT && $urandom_range(1))
                send_req(k, rand_key());
            else
                send_req(k, known_key());
        end
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = '0;
        key_id    = '0;
        err_cnt   = 0;
        idle_wd   = 0;
        calm      = 1'b0;
        timed_out = 1'b0;
        tbl_clear();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full();
        test_random(755);

        wait_drained();
        repeat (DRAIN_CYC) @(posedge clk);
        if (err_cnt == 0 && pending_q.size() == 0)
            $display("sorted_id_table_engine regression: pass");
        else
            $display("sorted_id_table_engine regression: fail");
        $finish;
    end
endmodule
`default_nettype wire
